### rtl/core/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg: shared types and constants of the cubic bezier tessellator
// Sequencer states, weight operation codes and register constants.
// ----------------------------------------------------------------------------
package cbt_pkg;

  // steps-per-segment register
  localparam int unsigned    CFG_W     = 7;
  localparam logic [CFG_W-1:0] STEPS_RST = 7'd16;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a control point
    ST_WGT,    // computing the four bernstein weights
    ST_MAC,    // accumulating weight times control point
    ST_DINIT,  // biasing the sum for the divider
    ST_DIV,    // restoring division by steps cubed
    ST_PUSH,   // handing a curve point to the output register
    ST_ERR,    // handing the too-few-points item to the output register
    ST_FIN     // end of segment window bookkeeping
  } cbt_state_t;

  // weight operations, run in this order on the shared multiplier
  typedef enum logic [2:0] {
    OP_UU,   // u*u
    OP_UUU,  // u^2*u -> w0
    OP_UUI,  // u^2*i -> w1/3
    OP_II,   // i*i
    OP_III,  // i^2*i -> w3
    OP_UII   // u*i^2 -> w2/3
  } cbt_op_t;

endpackage

### rtl/core/cubic_bezier_tessellator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator: cubic bezier curve evaluation
// Gathers control points into a window of four and emits steps points of the
// cubic bernstein sum per segment, rounded to nearest, using one shared
// multiplier and a one-bit-per-cycle restoring divider.
// Each curve point runs the weights on the shared multiplier, then for each
// coordinate four multiply-accumulates and a restoring divide by steps cubed.
// A point that completes no segment emits nothing, unless it closes a curve
// before any segment, which emits an error item. Not ready while a segment
// is being evaluated.
// Reset: synchronous active-low rst_n empties the window and sets steps to 16.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator #(
  parameter int unsigned MAX_STEPS  = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_wr_en,
  input  logic [cbt_pkg::CFG_W-1:0]               cfg_wr_data,  // steps_per_segment
  // control point input
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]        in_tdata,     // pos_x, pos_y, pos_z
  input  logic                                    in_tlast,     // curve_end
  // curve point output
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]        out_tdata,    // out_x, out_y, out_z
  output logic                                    out_tlast,    // run_last
  output logic                                    out_tuser     // too_few_points
);

  localparam int unsigned DW     = ((3*COORD_BITS+7)/8)*8;
  localparam int unsigned STEP_W = $clog2(MAX_STEPS+1);
  localparam int unsigned WGT_W  = $clog2(MAX_STEPS*MAX_STEPS*MAX_STEPS+1);
  localparam int unsigned ACC_W  = WGT_W + COORD_BITS + 1;
  localparam int unsigned BIT_W  = $clog2(COORD_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // control state
  cbt_pkg::cbt_state_t state_r, state_nxt;
  cbt_pkg::cbt_op_t    op_r, op_nxt;
  logic [cbt_pkg::CFG_W-1:0] cfg_steps_r;
  logic [1:0]          fill_r, fill_nxt;
  logic                seen_r, seen_nxt;
  logic                end_r, end_nxt;
  logic                phase_r, phase_nxt;
  logic [1:0]          j_r, j_nxt;
  logic [1:0]          c_r, c_nxt;
  logic [STEP_W-1:0]   i_r, i_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic                out_valid_r, out_valid_nxt;

  // datapath
  coord_t              px_r [4];
  coord_t              py_r [4];
  coord_t              pz_r [4];
  logic [WGT_W-1:0]    w_r [4];
  logic [WGT_W-1:0]    w_nxt [4];
  logic [2*STEP_W-1:0] u2_r, u2_nxt, i2_r, i2_nxt;
  logic [WGT_W-1:0]    s_r, s_nxt;
  logic [ACC_W-1:0]    bias_r;
  logic signed [ACC_W-1:0] mul_r, mul_p;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0]    rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [COORD_BITS-1:0] q_r, q_nxt;
  coord_t              res_x_r, res_y_r, res_z_r;
  coord_t              res_x_nxt, res_y_nxt, res_z_nxt;
  coord_t              out_x_r, out_y_r, out_z_r, out_x_nxt, out_y_nxt, out_z_nxt;
  logic                out_last_r, out_last_nxt, out_err_r, out_err_nxt;

  // combinational helpers
  logic [STEP_W-1:0]   steps_eff, u_val;
  coord_t              mul_a, pt_sel;
  logic [WGT_W-1:0]    mul_b, w_tri;
  logic                in_fire, out_free, seg_last, div_ge;
  logic                win_wr, win_shift;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign u_val    = steps_eff - i_r;
  assign seg_last = (i_r == steps_eff - STEP_W'(1));
  assign w_tri    = mul_r[WGT_W-1:0] + (mul_r[WGT_W-1:0] << 1);
  assign div_ge   = (rem_r >= dsr_r);

  // effective step count: zero counts as one, saturate at the maximum
  always_comb begin
    if (cfg_steps_r == '0) begin
      steps_eff = STEP_W'(1);
    end else if (int'(cfg_steps_r) > int'(MAX_STEPS)) begin
      steps_eff = STEP_W'(MAX_STEPS);
    end else begin
      steps_eff = STEP_W'(cfg_steps_r);
    end
  end

  // control point coordinate feeding the multiplier
  always_comb begin
    unique case (c_r)
      2'd0:    pt_sel = px_r[j_r];
      2'd1:    pt_sel = py_r[j_r];
      default: pt_sel = pz_r[j_r];
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = pt_sel;
    mul_b = w_r[j_r];
    if (state_r == cbt_pkg::ST_WGT) begin
      unique case (op_r)
        cbt_pkg::OP_UU:  begin mul_a = COORD_BITS'(u_val); mul_b = WGT_W'(u_val); end
        cbt_pkg::OP_UUU: begin mul_a = COORD_BITS'(u2_r);  mul_b = WGT_W'(u_val); end
        cbt_pkg::OP_UUI: begin mul_a = COORD_BITS'(u2_r);  mul_b = WGT_W'(i_r);   end
        cbt_pkg::OP_II:  begin mul_a = COORD_BITS'(i_r);   mul_b = WGT_W'(i_r);   end
        cbt_pkg::OP_III: begin mul_a = COORD_BITS'(i2_r);  mul_b = WGT_W'(i_r);   end
        default:         begin mul_a = COORD_BITS'(i2_r);  mul_b = WGT_W'(u_val); end
      endcase
    end
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbt_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (fill_r == 2'd3) begin
            state_nxt = cbt_pkg::ST_WGT;
          end else if (in_tlast && !seen_r) begin
            state_nxt = cbt_pkg::ST_ERR;
          end
        end
      end
      cbt_pkg::ST_WGT: begin
        if (phase_r && op_r == cbt_pkg::OP_UII) state_nxt = cbt_pkg::ST_MAC;
      end
      cbt_pkg::ST_MAC: begin
        if (phase_r && j_r == 2'd3) state_nxt = cbt_pkg::ST_DINIT;
      end
      cbt_pkg::ST_DINIT: state_nxt = cbt_pkg::ST_DIV;
      cbt_pkg::ST_DIV: begin
        if (bit_r == '0) state_nxt = (c_r == 2'd2) ? cbt_pkg::ST_PUSH : cbt_pkg::ST_MAC;
      end
      cbt_pkg::ST_PUSH: begin
        if (out_free) state_nxt = seg_last ? cbt_pkg::ST_FIN : cbt_pkg::ST_WGT;
      end
      cbt_pkg::ST_ERR: begin
        if (out_free) state_nxt = cbt_pkg::ST_IDLE;
      end
      cbt_pkg::ST_FIN: state_nxt = cbt_pkg::ST_IDLE;
      default: state_nxt = cbt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath next values
  always_comb begin
    in_tready     = (state_r == cbt_pkg::ST_IDLE);
    win_wr        = 1'b0;
    win_shift     = 1'b0;
    op_nxt        = op_r;
    fill_nxt      = fill_r;
    seen_nxt      = seen_r;
    end_nxt       = end_r;
    phase_nxt     = phase_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    i_nxt         = i_r;
    bit_nxt       = bit_r;
    w_nxt         = w_r;
    u2_nxt        = u2_r;
    i2_nxt        = i2_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    q_nxt         = q_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_z_nxt     = res_z_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      // take a control point into the window
      cbt_pkg::ST_IDLE: begin
        if (in_fire) begin
          win_wr  = 1'b1;
          end_nxt = in_tlast;
          if (fill_r == 2'd3) begin
            i_nxt     = '0;
            op_nxt    = cbt_pkg::OP_UU;
            phase_nxt = 1'b0;
          end else if (in_tlast) begin
            fill_nxt = '0;
            seen_nxt = 1'b0;
          end else begin
            fill_nxt = fill_r + 2'd1;
          end
        end
      end
      // weights: issue on phase 0, write back on phase 1
      cbt_pkg::ST_WGT: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          unique case (op_r)
            cbt_pkg::OP_UU: begin
              u2_nxt = mul_r[2*STEP_W-1:0];
              op_nxt = cbt_pkg::OP_UUU;
            end
            cbt_pkg::OP_UUU: begin
              w_nxt[0] = mul_r[WGT_W-1:0];
              // at i = 0 the first weight is steps cubed
              if (i_r == '0) s_nxt = mul_r[WGT_W-1:0];
              op_nxt = cbt_pkg::OP_UUI;
            end
            cbt_pkg::OP_UUI: begin
              w_nxt[1] = w_tri;
              op_nxt   = cbt_pkg::OP_II;
            end
            cbt_pkg::OP_II: begin
              i2_nxt = mul_r[2*STEP_W-1:0];
              op_nxt = cbt_pkg::OP_III;
            end
            cbt_pkg::OP_III: begin
              w_nxt[3] = mul_r[WGT_W-1:0];
              op_nxt   = cbt_pkg::OP_UII;
            end
            default: begin
              w_nxt[2] = w_tri;
              op_nxt   = cbt_pkg::OP_UU;
              c_nxt    = 2'd0;
              j_nxt    = 2'd0;
              acc_nxt  = '0;
            end
          endcase
        end
      end
      // weighted sum of one coordinate
      cbt_pkg::ST_MAC: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          acc_nxt = acc_r + mul_r;
          j_nxt   = j_r + 2'd1;
        end
      end
      // add half the divisor for rounding and offset the quotient to be positive
      cbt_pkg::ST_DINIT: begin
        rem_nxt = $unsigned(acc_r) + bias_r;
        dsr_nxt = ACC_W'(s_r) << (COORD_BITS-1);
        bit_nxt = BIT_W'(COORD_BITS-1);
        q_nxt   = '0;
      end
      // one quotient bit per cycle
      cbt_pkg::ST_DIV: begin
        rem_nxt = div_ge ? rem_r - dsr_r : rem_r;
        dsr_nxt = dsr_r >> 1;
        q_nxt   = {q_r[COORD_BITS-2:0], div_ge};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          // remove the quotient offset; the blend of the points stays in range
          unique case (c_r)
            2'd0:    res_x_nxt = {~q_nxt[COORD_BITS-1], q_nxt[COORD_BITS-2:0]};
            2'd1:    res_y_nxt = {~q_nxt[COORD_BITS-1], q_nxt[COORD_BITS-2:0]};
            default: res_z_nxt = {~q_nxt[COORD_BITS-1], q_nxt[COORD_BITS-2:0]};
          endcase
          c_nxt     = c_r + 2'd1;
          j_nxt     = 2'd0;
          acc_nxt   = '0;
          phase_nxt = 1'b0;
        end
      end
      // hand the curve point over
      cbt_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_z_nxt     = res_z_r;
          out_last_nxt  = seg_last;
          out_err_nxt   = 1'b0;
          i_nxt         = i_r + STEP_W'(1);
          phase_nxt     = 1'b0;
        end
      end
      // curve closed before any segment
      cbt_pkg::ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_z_nxt     = '0;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b1;
        end
      end
      // end point becomes the start of the next segment
      cbt_pkg::ST_FIN: begin
        win_shift = 1'b1;
        if (end_r) begin
          fill_nxt = '0;
          seen_nxt = 1'b0;
        end else begin
          fill_nxt = 2'd1;
          seen_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbt_pkg::ST_IDLE;
      cfg_steps_r <= cbt_pkg::STEPS_RST;
      fill_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= cbt_pkg::OP_UU;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      phase_r     <= phase_nxt;
      if (cfg_wr_en) cfg_steps_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    j_r        <= j_nxt;
    c_r        <= c_nxt;
    i_r        <= i_nxt;
    bit_r      <= bit_nxt;
    w_r        <= w_nxt;
    u2_r       <= u2_nxt;
    i2_r       <= i2_nxt;
    s_r        <= s_nxt;
    bias_r     <= (ACC_W'(s_r) << (COORD_BITS-1)) + ACC_W'(s_r >> 1);
    mul_r      <= mul_p;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    q_r        <= q_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_z_r    <= res_z_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // point window
  always_ff @(posedge clk) begin
    if (win_wr) begin
      px_r[fill_r] <= in_tdata[COORD_BITS-1:0];
      py_r[fill_r] <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      pz_r[fill_r] <= in_tdata[3*COORD_BITS-1:2*COORD_BITS];
    end else if (win_shift) begin
      px_r[0] <= px_r[3];
      py_r[0] <= py_r[3];
      pz_r[0] <= pz_r[3];
    end
  end

  // output channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'({out_z_r, out_y_r, out_x_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule
